// File: rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
// No dependencies; every other file of the block but tcw_ram imports this package.
package tcw_pkg;

  localparam int COLS_DEFAULT = 80;
  localparam int ROWS_DEFAULT = 25;

  localparam int COL_W  = 8;
  localparam int ROW_W  = 6;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE       = 8'd10;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } tcw_op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_DRAIN
  } tcw_state_e;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_line;
    logic              scrolled;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attribute;
    logic              bad_position;
  } tcw_result_t;

endpackage

// File: rtl/tcw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tcw_out_buf.sv
// Two-entry result buffer (output register plus skid register) for the
// console writer. Depends on tcw_pkg for the result struct.
module tcw_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tcw_pkg::tcw_result_t push_data_i,
  output logic                 skid_full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tcw_pkg::tcw_result_t out_data_o
);
  import tcw_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  tcw_result_t out_q, out_d;
  tcw_result_t skid_q, skid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // Advance the skid entry; a new push refills it.
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign skid_full_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed while skid entry is occupied");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while output register is empty");
`endif

endmodule

// File: rtl/text_console_writer.sv
// Text console writer: top level with the command sequencer and cursor.
// Depends on tcw_pkg, tcw_ram and tcw_out_buf.
//
// Character screen of ROWS x COLS cells (attribute in the high byte, character in the low
// byte) held in one synchronous RAM, with the cursor kept as column and row registers. After
// reset the block sweeps the RAM to zero, one cell a cycle, and holds in_stall_o high
// meanwhile. Put character and set cursor leave the sequencer idle; read cell passes through
// a read state first, because the RAM read data is registered. A put that runs past the last
// cell and a clear screen each walk every cell through the RAM's one read and one write port,
// one cell a cycle, then pass a drain state before the next transfer is accepted.
// One result comes out per accepted transfer, in order; a two-entry output buffer lets the
// next transfer enter while a result waits. default_attribute is written through cfg_we_i.
module text_console_writer #(
  parameter int COLS = tcw_pkg::COLS_DEFAULT,
  parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                operation_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::ATTR_W-1:0] attribute_i,
  input  logic                      at_position_i,
  input  logic [tcw_pkg::COL_W-1:0]  column_i,
  input  logic [tcw_pkg::ROW_W-1:0]  line_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [tcw_pkg::COL_W-1:0]  cursor_column_o,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_line_o,
  output logic                      scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0] read_char_o,
  output logic [tcw_pkg::ATTR_W-1:0] read_attribute_o,
  output logic                      bad_position_o
);
  import tcw_pkg::*;

  localparam int CELLS     = COLS * ROWS;
  localparam int TOP_CELLS = CELLS - COLS;
  localparam int AW        = $clog2(CELLS);

  localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0]    TOP_END   = AW'(TOP_CELLS);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

  tcw_state_e state_q, state_d;

  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [ATTR_W-1:0] default_attr_q;
  logic [AW-1:0]     idx_q, idx_d;
  logic              clear_mode_q, clear_mode_d;
  logic              pend_q;
  logic [AW-1:0]     pend_addr_q;
  logic              pend_mask_q;
  tcw_result_t       res_q;

  // RAM ports
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // Result path
  logic        push;
  tcw_result_t push_data, res_now;
  tcw_result_t out_data;
  logic        skid_full;

  // Decode of the incoming transfer
  tcw_op_e           op;
  logic              accept;
  logic              on_screen, use_cursor, bad;
  logic [COL_W-1:0]  sel_col, put_col;
  logic [ROW_W-1:0]  sel_row, put_row;
  logic [AW-1:0]     cell_addr;
  logic              is_nl, wrap, last_row, put_scroll;
  logic [ATTR_W-1:0] eff_attr;
  logic              walk_mask;
  logic [AW-1:0]     walk_src;

  assign op         = tcw_op_e'(operation_i);
  assign in_stall_o = (state_q != ST_IDLE) || skid_full;
  assign accept     = in_valid_i && !in_stall_o;

  assign on_screen  = ({1'b0, column_i} < (COL_W + 1)'(COLS)) &&
                      ({1'b0, line_i} < (ROW_W + 1)'(ROWS));
  assign use_cursor = (op == OP_PUT) && !at_position_i;
  assign bad        = (op != OP_CLEAR) && !use_cursor && !on_screen;
  assign sel_col    = use_cursor ? cur_col_q : column_i;
  assign sel_row    = use_cursor ? cur_row_q : line_i;
  assign cell_addr  = AW'(int'(sel_row) * COLS + int'(sel_col));

  // Newline behaves as a put at the last column that writes nothing.
  assign is_nl      = (char_code_i == NEWLINE_CODE);
  assign wrap       = is_nl || (sel_col == LAST_COL);
  assign last_row   = (sel_row == LAST_ROW);
  assign put_scroll = wrap && last_row;
  assign put_col    = wrap ? '0 : COL_W'(sel_col + COL_W'(1));
  assign put_row    = (wrap && !last_row) ? ROW_W'(sel_row + ROW_W'(1)) : sel_row;
  assign eff_attr   = (attribute_i == '0) ? default_attr_q : attribute_i;

  // Scroll copies each cell from one row below; the bottom row and a clear
  // rewrite the cell with its own character byte dropped.
  assign walk_mask = clear_mode_q || (idx_q >= TOP_END);
  assign walk_src  = walk_mask ? idx_q : AW'(int'(idx_q) + COLS);

  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (accept && !bad) begin
      case (op)
        OP_PUT: begin
          cur_col_d = put_col;
          cur_row_d = put_row;
        end
        OP_SET: begin
          cur_col_d = column_i;
          cur_row_d = line_i;
        end
        OP_CLEAR: begin
          cur_col_d = '0;
          cur_row_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_now                = '0;
    res_now.cursor_column  = cur_col_d;
    res_now.cursor_line    = cur_row_d;
    res_now.scrolled       = (op == OP_PUT) && !bad && put_scroll;
    res_now.bad_position   = bad;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (idx_q == LAST_CELL) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && !bad) begin
          if (op == OP_READ) begin
            state_d = ST_READ;
          end else if (op == OP_CLEAR || (op == OP_PUT && put_scroll)) begin
            state_d = ST_WALK;
          end
        end
      end
      ST_READ:  state_d = ST_IDLE;
      ST_WALK: begin
        if (idx_q == LAST_CELL) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = cell_addr;
    ram_wdata    = {eff_attr, char_code_i};
    ram_re       = 1'b0;
    ram_raddr    = cell_addr;
    push         = 1'b0;
    push_data    = res_now;
    idx_d        = idx_q;
    clear_mode_d = clear_mode_q;
    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = pend_mask_q ? {ram_rdata[CELL_W-1:CHAR_W], CHAR_W'(0)} : ram_rdata;
    end
    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = '0;
        idx_d     = AW'(idx_q + AW'(1));
      end
      ST_IDLE: begin
        idx_d        = '0;
        clear_mode_d = (op == OP_CLEAR);
        ram_we       = accept && (op == OP_PUT) && !bad && !is_nl;
        ram_re       = accept && (op == OP_READ) && !bad;
        push         = accept && !(op == OP_READ && !bad) && (op != OP_CLEAR) &&
                       !(op == OP_PUT && !bad && put_scroll);
      end
      ST_READ: begin
        push                     = 1'b1;
        push_data                = res_q;
        push_data.read_char      = ram_rdata[CHAR_W-1:0];
        push_data.read_attribute = ram_rdata[CELL_W-1:CHAR_W];
      end
      ST_WALK: begin
        ram_re    = 1'b1;
        ram_raddr = walk_src;
        idx_d     = AW'(idx_q + AW'(1));
      end
      ST_DRAIN: begin
        push      = 1'b1;
        push_data = res_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_INIT;
      idx_q          <= '0;
      cur_col_q      <= '0;
      cur_row_q      <= '0;
      default_attr_q <= DEFAULT_ATTR_RESET;
      clear_mode_q   <= 1'b0;
      pend_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
      clear_mode_q <= clear_mode_d;
      pend_q       <= (state_q == ST_WALK);
      if (cfg_we_i) begin
        default_attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= idx_q;
    pend_mask_q <= walk_mask;
    if (accept) begin
      res_q <= res_now;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tcw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .skid_full_o (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign cursor_column_o  = out_data.cursor_column;
  assign cursor_line_o    = out_data.cursor_line;
  assign scrolled_o       = out_data.scrolled;
  assign read_char_o      = out_data.read_char;
  assign read_attribute_o = out_data.read_attribute;
  assign bad_position_o   = out_data.bad_position;

`ifndef SYNTHESIS
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_col_q} < (COL_W + 1)'(COLS)) && ({1'b0, cur_row_q} < (ROW_W + 1)'(ROWS)))
    else $error("cursor left the screen");

  a_no_same_cell_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && ram_re) |-> (ram_raddr != pend_addr_q))
    else $error("walk reads the cell it is writing back");

  a_scroll_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_PUT && !bad && put_scroll) |=> (state_q == ST_WALK))
    else $error("put past the last cell did not start the scroll walk");

  a_read_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_READ && !bad) |=> push)
    else $error("cell read gave no result one cycle later");
`endif

endmodule

// File: verif/tcw_screen_checker.sv
// Checker for the text console writer: watches the command and status channels,
// keeps its own screen and cursor image and compares every status transfer.
// Depends on tcw_pkg for the operation codes, the field widths and the screen size.
module tcw_screen_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [1:0]                 operation_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::ATTR_W-1:0] attribute_i,
  input  logic                       at_position_i,
  input  logic [tcw_pkg::COL_W-1:0]  column_i,
  input  logic [tcw_pkg::ROW_W-1:0]  line_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [tcw_pkg::COL_W-1:0]  cursor_column_i,
  input  logic [tcw_pkg::ROW_W-1:0]  cursor_line_i,
  input  logic                       scrolled_i,
  input  logic [tcw_pkg::CHAR_W-1:0] read_char_i,
  input  logic [tcw_pkg::ATTR_W-1:0] read_attribute_i,
  input  logic                       bad_position_i,
  output int                         errors_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLS  = COLS_DEFAULT;
  localparam int ROWS  = ROWS_DEFAULT;
  localparam int CELLS = COLS * ROWS;

  logic [CELL_W-1:0] screen_img [CELLS];
  int unsigned       cursor_idx;
  logic [ATTR_W-1:0] default_attr;
  tcw_result_t       predicted_status_q [$];

  function automatic void clear_screen_img();
    for (int i = 0; i < CELLS; i++) begin
      screen_img[i] = '0;
    end
  endfunction

  function automatic void scroll_screen_img();
    for (int i = 0; i < CELLS - COLS; i++) begin
      screen_img[i] = screen_img[i + COLS];
    end
    // keep the attributes of the new bottom row, blank its characters
    for (int i = CELLS - COLS; i < CELLS; i++) begin
      screen_img[i][CHAR_W-1:0] = '0;
    end
  endfunction

  function automatic tcw_result_t apply_console_op(
    input tcw_op_e           op,
    input logic [CHAR_W-1:0] ch,
    input logic [ATTR_W-1:0] attr,
    input logic              at_pos,
    input logic [COL_W-1:0]  col,
    input logic [ROW_W-1:0]  row
  );
    tcw_result_t       res;
    bit                on_screen;
    int unsigned       target;
    int unsigned       pos;
    logic [ATTR_W-1:0] cell_attr;
    res       = '0;
    on_screen = (int'(col) < COLS) && (int'(row) < ROWS);
    target    = on_screen ? int'(row) * COLS + int'(col) : 0;
    case (op)
      OP_PUT: begin
        if (at_pos && !on_screen) begin
          res.bad_position = 1'b1;
        end else begin
          pos = at_pos ? target : cursor_idx;
          if (pos >= CELLS) pos = 0;
          if (ch == NEWLINE_CODE) begin
            pos = (pos / COLS) * COLS + COLS - 1;
          end else begin
            cell_attr = (attr == '0) ? default_attr : attr;
            screen_img[pos] = {cell_attr, ch};
          end
          pos++;
          if (pos >= CELLS) begin
            scroll_screen_img();
            pos = CELLS - COLS;
            res.scrolled = 1'b1;
          end
          cursor_idx = pos;
        end
      end
      OP_SET: begin
        if (on_screen) cursor_idx = target;
        else res.bad_position = 1'b1;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_img[i][CHAR_W-1:0] = '0;
        end
        cursor_idx = 0;
      end
      default: begin
        if (on_screen) {res.read_attribute, res.read_char} = screen_img[target];
        else res.bad_position = 1'b1;
      end
    endcase
    res.cursor_column = COL_W'(cursor_idx % COLS);
    res.cursor_line   = ROW_W'(cursor_idx / COLS);
    return res;
  endfunction

  function automatic void check_field(input string fname, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, fname, want, got);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tcw_result_t want;
    if (!rst_ni) begin
      clear_screen_img();
      cursor_idx   = 0;
      default_attr = DEFAULT_ATTR_RESET;
      predicted_status_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) default_attr = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        predicted_status_q.push_back(apply_console_op(tcw_op_e'(operation_i), char_code_i,
                                                      attribute_i, at_position_i,
                                                      column_i, line_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (predicted_status_q.size() == 0) begin
          $display("%0t: status transfer with nothing expected, actual col %0d line %0d",
                   $realtime, cursor_column_i, cursor_line_i);
          errors_o++;
        end else begin
          want = predicted_status_q.pop_front();
          check_field("cursor_column", want.cursor_column, cursor_column_i);
          check_field("cursor_line", want.cursor_line, cursor_line_i);
          check_field("scrolled", want.scrolled, scrolled_i);
          check_field("read_char", want.read_char, read_char_i);
          check_field("read_attribute", want.read_attribute, read_attribute_i);
          check_field("bad_position", want.bad_position, bad_position_i);
        end
      end
      pending_o = predicted_status_q.size();
    end
  end

endmodule

// File: verif/tb.sv
// Testbench top for the text console writer: clock, reset, command stimulus,
// status back-pressure, attribute register writes, watchdog and verdict.
// Depends on tcw_pkg, text_console_writer and tcw_screen_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLS       = COLS_DEFAULT;
  localparam int ROWS       = ROWS_DEFAULT;
  localparam int CELLS      = COLS * ROWS;
  localparam int IDLE_LIMIT = 10000;
  localparam int DRAIN_WAIT = CELLS + 100;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        operation;
  logic [CHAR_W-1:0] char_code;
  logic [ATTR_W-1:0] attribute;
  logic              at_position;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  line;
  logic              out_valid;
  logic              out_stall;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_line;
  logic              scrolled;
  logic [CHAR_W-1:0] read_char;
  logic [ATTR_W-1:0] read_attribute;
  logic              bad_position;
  int                errors;
  int                pending;
  int                idle_cycles;
  bit                cmd_burst;
  bit                status_burst;

  text_console_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .char_code_i     (char_code),
    .attribute_i     (attribute),
    .at_position_i   (at_position),
    .column_i        (column),
    .line_i          (line),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .cursor_column_o (cursor_column),
    .cursor_line_o   (cursor_line),
    .scrolled_o      (scrolled),
    .read_char_o     (read_char),
    .read_attribute_o(read_attribute),
    .bad_position_o  (bad_position)
  );

  tcw_screen_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .char_code_i     (char_code),
    .attribute_i     (attribute),
    .at_position_i   (at_position),
    .column_i        (column),
    .line_i          (line),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .cursor_column_i (cursor_column),
    .cursor_line_i   (cursor_line),
    .scrolled_i      (scrolled),
    .read_char_i     (read_char),
    .read_attribute_i(read_attribute),
    .bad_position_i  (bad_position),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: any stretch without a transfer on either channel counts.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Status side: stall for a random number of cycles before each transfer.
  initial begin
    int gap;
    out_stall    = 1'b1;
    status_burst = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0) status_burst = !status_burst;
      gap = status_burst ? 0 : $urandom_range(0, 19);
      repeat (gap) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_cmd(input tcw_op_e op, input logic [CHAR_W-1:0] ch,
                          input logic [ATTR_W-1:0] attr, input logic at_pos,
                          input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    int gap;
    if ($urandom_range(0, 29) == 0) cmd_burst = !cmd_burst;
    gap = cmd_burst ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    operation   <= op;
    char_code   <= ch;
    attribute   <= attr;
    at_position <= at_pos;
    column      <= col;
    line        <= row;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, then hold until every status has come back and the block takes input.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || in_stall);
  endtask

  task automatic write_default_attr(input logic [ATTR_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Bias toward the right edge and the bottom rows so that puts run into scrolls.
  function automatic logic [COL_W-1:0] pick_col();
    int d;
    d = $urandom_range(0, 99);
    if (d < 15) return COL_W'($urandom_range(0, 255));
    if (d < 55) return COL_W'($urandom_range(COLS - 8, COLS - 1));
    return COL_W'($urandom_range(0, COLS - 1));
  endfunction

  function automatic logic [ROW_W-1:0] pick_row();
    int d;
    d = $urandom_range(0, 99);
    if (d < 15) return ROW_W'($urandom_range(0, 63));
    if (d < 60) return ROW_W'($urandom_range(ROWS - 3, ROWS - 1));
    return ROW_W'($urandom_range(0, ROWS - 1));
  endfunction

  task automatic run_random(input int count);
    int                d;
    tcw_op_e           op;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    for (int n = 0; n < count; n++) begin
      d = $urandom_range(0, 99);
      if (d < 2) op = OP_CLEAR;
      else if (d < 17) op = OP_SET;
      else if (d < 37) op = OP_READ;
      else op = OP_PUT;
      ch   = ($urandom_range(0, 99) < 12) ? NEWLINE_CODE : CHAR_W'($urandom_range(0, 255));
      attr = ($urandom_range(0, 99) < 20) ? '0 : ATTR_W'($urandom_range(0, 255));
      send_cmd(op, ch, attr, $urandom_range(0, 99) < 30, pick_col(), pick_row());
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    operation   = OP_PUT;
    char_code   = '0;
    attribute   = '0;
    at_position = 1'b0;
    column      = '0;
    line        = '0;
    cmd_burst   = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: default attribute, scroll from a positioned put, newline on the
    // bottom row, off-screen coordinates, clear keeping attributes.
    send_cmd(OP_PUT,   8'h41,        8'h00, 1'b0, 8'd0,   6'd0);
    send_cmd(OP_READ,  8'h00,        8'h00, 1'b0, 8'd0,   6'd0);
    send_cmd(OP_PUT,   8'h00,        8'hFF, 1'b0, 8'd0,   6'd0);
    send_cmd(OP_PUT,   8'hFF,        8'hFF, 1'b1, 8'd79,  6'd24);
    send_cmd(OP_READ,  8'h00,        8'h00, 1'b0, 8'd79,  6'd23);
    send_cmd(OP_READ,  8'h00,        8'h00, 1'b0, 8'd79,  6'd24);
    send_cmd(OP_PUT,   NEWLINE_CODE, 8'h12, 1'b0, 8'd0,   6'd0);
    send_cmd(OP_SET,   8'h00,        8'h00, 1'b0, 8'd80,  6'd0);
    send_cmd(OP_SET,   8'h00,        8'h00, 1'b0, 8'd0,   6'd25);
    send_cmd(OP_SET,   8'hFF,        8'hFF, 1'b1, 8'd255, 6'd63);
    send_cmd(OP_PUT,   8'h42,        8'h07, 1'b1, 8'd200, 6'd5);
    send_cmd(OP_READ,  8'h00,        8'h00, 1'b0, 8'd79,  6'd25);
    send_cmd(OP_SET,   8'h00,        8'h00, 1'b0, 8'd79,  6'd24);
    send_cmd(OP_PUT,   8'h5A,        8'h80, 1'b0, 8'd0,   6'd0);
    send_cmd(OP_PUT,   NEWLINE_CODE, 8'h00, 1'b1, 8'd3,   6'd10);
    send_cmd(OP_READ,  8'h00,        8'h00, 1'b1, 8'd255, 6'd0);
    send_cmd(OP_CLEAR, 8'hFF,        8'hFF, 1'b1, 8'd255, 6'd63);
    send_cmd(OP_READ,  8'h00,        8'h00, 1'b0, 8'd79,  6'd22);
    send_cmd(OP_PUT,   8'h71,        8'h01, 1'b0, 8'd255, 6'd63);

    write_default_attr(8'h00);
    send_cmd(OP_PUT,  8'h55, 8'h00, 1'b1, 8'd10, 6'd10);
    send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd10, 6'd10);
    write_default_attr(8'hFF);
    send_cmd(OP_PUT,  8'hAA, 8'h00, 1'b1, 8'd11, 6'd10);
    send_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd11, 6'd10);

    run_random(150);
    for (int phase = 0; phase < 4; phase++) begin
      write_default_attr(ATTR_W'($urandom_range(0, 255)));
      run_random(150);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // walk out any scroll or clear still running and catch stray transfers
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_out_buf.sv
rtl/text_console_writer.sv
verif/tcw_screen_checker.sv
verif/tb.sv
